@@ rtl/core/bcd_telemetry_frame_parser_defines.svh @@
// Assertion helpers shared by the frame parser modules.
`ifndef BCD_TELEMETRY_FRAME_PARSER_DEFINES_SVH
`define BCD_TELEMETRY_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BCDTFP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bcdtfp assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BCDTFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bcdtfp assertion failed");

`endif

@@ rtl/core/bcdtfp_pkg.sv @@
package bcdtfp_pkg;

  localparam int HEADER_LEN_DEF   = 4;
  localparam int FRAME_LENGTH_DEF = 13;

  localparam int PAYLOAD_FIRST = 4;
  localparam int PAYLOAD_LAST  = 11;
  localparam int PAYLOAD_DEPTH = 8;

  localparam int VAL_W   = 15;
  localparam int TICK_W  = 16;
  localparam int PADDR_W = 4;

  localparam logic [TICK_W-1:0] TICK_MAX = '1;

  localparam logic [TICK_W-1:0] GAP_LIMIT_RST  = 16'd100;
  localparam logic [TICK_W-1:0] DATA_LIMIT_RST = 16'd10000;

  localparam logic [3:0] NIBBLE_MASK    = 4'hF;
  localparam logic [7:0] BCD_RADIX      = 8'd10;
  localparam logic [VAL_W-1:0] BCD_PAIR = 15'd100;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic EVT_FRAME   = 1'b0;
  localparam logic EVT_TIMEOUT = 1'b1;

  typedef enum logic [1:0] {
    REG_HEADER_BYTES  = 2'd0,
    REG_END_BYTE      = 2'd1,
    REG_GAP_LIMIT     = 2'd2,
    REG_DATA_LIMIT    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [31:0]       header_bytes;
    logic [7:0]        end_byte;
    logic [TICK_W-1:0] gap_limit_ms;
    logic [TICK_W-1:0] data_limit_ms;
  } cfg_t;

  typedef struct packed {
    logic             event_res;
    logic [VAL_W-1:0] ac_voltage;
    logic [VAL_W-1:0] power_value;
    logic [VAL_W-1:0] battery_tenths;
    logic [VAL_W-1:0] temperature_value;
  } result_t;

  // Two packed-BCD digits, weighted as they are (no digit check).
  function automatic logic [7:0] bcd_byte(input logic [7:0] b);
    logic [3:0] hi_n;
    logic [3:0] lo_n;
    hi_n = b[7:4] & NIBBLE_MASK;
    lo_n = b[3:0] & NIBBLE_MASK;
    return 8'({4'b0, hi_n} * BCD_RADIX) + {4'b0, lo_n};
  endfunction

  function automatic logic [VAL_W-1:0] bcd_pair(input logic [7:0] hi, input logic [7:0] lo);
    logic [7:0] h;
    logic [7:0] l;
    h = bcd_byte(hi);
    l = bcd_byte(lo);
    return VAL_W'({7'b0, h} * BCD_PAIR) + {7'b0, l};
  endfunction

endpackage

@@ rtl/core/bcdtfp_cfg.sv @@
module bcdtfp_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bcdtfp_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output bcdtfp_pkg::cfg_t                cfg
);
  import bcdtfp_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_HEADER_BYTES: cfg_nxt.header_bytes  = pwdata;
        REG_END_BYTE:     cfg_nxt.end_byte      = pwdata[7:0];
        REG_GAP_LIMIT:    cfg_nxt.gap_limit_ms  = pwdata[TICK_W-1:0];
        REG_DATA_LIMIT:   cfg_nxt.data_limit_ms = pwdata[TICK_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_HEADER_BYTES: prdata = cfg_r.header_bytes;
      REG_END_BYTE:     prdata = {24'b0, cfg_r.end_byte};
      REG_GAP_LIMIT:    prdata = {16'b0, cfg_r.gap_limit_ms};
      REG_DATA_LIMIT:   prdata = {16'b0, cfg_r.data_limit_ms};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_bytes  <= '0;
      cfg_r.end_byte      <= '0;
      cfg_r.gap_limit_ms  <= GAP_LIMIT_RST;
      cfg_r.data_limit_ms <= DATA_LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/core/bcdtfp_core.sv @@
module bcdtfp_core #(
  parameter int HEADER_LEN   = bcdtfp_pkg::HEADER_LEN_DEF,
  parameter int FRAME_LENGTH = bcdtfp_pkg::FRAME_LENGTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bcdtfp_pkg::cfg_t     cfg,
  input  logic                 in_fire,
  input  logic                 in_opcode,
  input  logic [7:0]           in_rx_byte,
  output logic                 res_valid,
  output bcdtfp_pkg::result_t  res
);
  import bcdtfp_pkg::*;

  localparam int CNT_W = $clog2(FRAME_LENGTH + 1);
  localparam int PIDX_W = $clog2(PAYLOAD_DEPTH);

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [TICK_W-1:0] tsb_r, tsb_nxt;
  logic [TICK_W-1:0] tsf_r, tsf_nxt;
  logic              seen_r, seen_nxt;
  logic              rep_r, rep_nxt;
  logic [7:0]        payload_r [PAYLOAD_DEPTH];

  logic [TICK_W-1:0] tsb_inc;
  logic [TICK_W-1:0] tsf_inc;
  logic [7:0]        want;
  logic              pl_we;
  logic [PIDX_W-1:0] pl_idx;
  logic              frame_done;
  logic              timeout_hit;

  assign tsb_inc = (tsb_r == TICK_MAX) ? TICK_MAX : tsb_r + 1'b1;
  assign tsf_inc = (tsf_r == TICK_MAX) ? TICK_MAX : tsf_r + 1'b1;
  assign want    = cfg.header_bytes[{cnt_r[1:0], 3'b000} +: 8];
  assign pl_idx  = PIDX_W'(cnt_r[PIDX_W-1:0] - PIDX_W'(PAYLOAD_FIRST));

  always_comb begin
    cnt_nxt     = cnt_r;
    tsb_nxt     = tsb_r;
    tsf_nxt     = tsf_r;
    seen_nxt    = seen_r;
    rep_nxt     = rep_r;
    pl_we       = 1'b0;
    frame_done  = 1'b0;
    timeout_hit = 1'b0;
    if (in_fire) begin
      if (in_opcode == OP_TICK) begin
        tsb_nxt = tsb_inc;
        tsf_nxt = tsf_inc;
        // drop a partial frame after too long a silence
        if (cnt_r != '0 && tsb_inc > cfg.gap_limit_ms) cnt_nxt = '0;
        if (seen_r && !rep_r && tsf_inc > cfg.data_limit_ms) begin
          timeout_hit = 1'b1;
          rep_nxt     = 1'b1;
        end
      end else begin
        tsb_nxt = '0;
        pl_we   = (cnt_r >= CNT_W'(PAYLOAD_FIRST)) && (cnt_r <= CNT_W'(PAYLOAD_LAST))
                  && (cnt_r < CNT_W'(FRAME_LENGTH));
        priority if (cnt_r >= CNT_W'(FRAME_LENGTH)) begin
          cnt_nxt = '0;
        end else if (cnt_r < CNT_W'(HEADER_LEN)) begin
          cnt_nxt = (in_rx_byte == want) ? cnt_r + 1'b1 : '0;
        end else if (cnt_r < CNT_W'(FRAME_LENGTH - 1)) begin
          cnt_nxt = cnt_r + 1'b1;
        end else begin
          cnt_nxt = '0;
          if (in_rx_byte == cfg.end_byte) begin
            frame_done = 1'b1;
            seen_nxt   = 1'b1;
            rep_nxt    = 1'b0;
            tsf_nxt    = '0;
          end
        end
      end
    end
  end

  always_comb begin
    res_valid = frame_done || timeout_hit;
    res       = '0;
    if (frame_done) begin
      res.event_res         = EVT_FRAME;
      res.ac_voltage        = bcd_pair(payload_r[0], payload_r[1]);
      res.power_value       = bcd_pair(payload_r[2], payload_r[3]);
      res.battery_tenths    = bcd_pair(payload_r[4], payload_r[5]);
      res.temperature_value = bcd_pair(payload_r[6], payload_r[7]);
    end else if (timeout_hit) begin
      res.event_res = EVT_TIMEOUT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      tsb_r  <= '0;
      tsf_r  <= '0;
      seen_r <= 1'b0;
      rep_r  <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      tsb_r  <= tsb_nxt;
      tsf_r  <= tsf_nxt;
      seen_r <= seen_nxt;
      rep_r  <= rep_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pl_we) payload_r[pl_idx] <= in_rx_byte;
  end

`include "bcd_telemetry_frame_parser_defines.svh"

  `BCDTFP_ASSERT_NOW(a_cnt_in_range, clk, rst_n, 1'b1, cnt_r <= CNT_W'(FRAME_LENGTH - 1))
  `BCDTFP_ASSERT_NEXT(a_frame_restarts_timer, clk, rst_n, frame_done,
                      seen_r && !rep_r && tsf_r == '0 && cnt_r == '0)

endmodule

@@ rtl/core/bcdtfp_out.sv @@
module bcdtfp_out (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  bcdtfp_pkg::result_t  push_data,
  output logic                 up_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output bcdtfp_pkg::result_t  out_data
);
  import bcdtfp_pkg::*;

  logic    main_v_r, main_v_nxt;
  logic    skid_v_r, skid_v_nxt;
  result_t main_d_r, main_d_nxt;
  result_t skid_d_r, skid_d_nxt;

  assign up_ready  = !skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_d_r;

  always_comb begin
    main_v_nxt = main_v_r;
    main_d_nxt = main_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    if (!main_v_r || out_ready) begin
      // output slot frees up: refill from skid first, else from the new request
      if (skid_v_r) begin
        main_v_nxt = 1'b1;
        main_d_nxt = skid_d_r;
        skid_v_nxt = 1'b0;
      end else begin
        main_v_nxt = push;
        main_d_nxt = push_data;
      end
    end else if (push) begin
      skid_v_nxt = 1'b1;
      skid_d_nxt = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_d_r <= main_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

`include "bcd_telemetry_frame_parser_defines.svh"

  `BCDTFP_ASSERT_NOW(a_skid_behind_main, clk, rst_n, skid_v_r, main_v_r)
  `BCDTFP_ASSERT_NOW(a_no_push_when_full, clk, rst_n, skid_v_r, !push)
  `BCDTFP_ASSERT_NEXT(a_skid_drains, clk, rst_n, skid_v_r && out_ready,
                      main_v_r && !skid_v_r)

endmodule

@@ rtl/core/bcd_telemetry_frame_parser.sv @@
// Telemetry frame parser for a serial link carrying packed-BCD readings.
// Input channel (in_valid/in_ready): each request is either a received byte
// (in_opcode byte, data on in_rx_byte) or a one-millisecond tick.
// Result channel (out_valid/out_ready): a decoded frame (event_res 0 with
// AC voltage, power, battery tenths and temperature) or a single data
// timeout (event_res 1, values zero). Most requests give no result.
// Configuration: APB-style registers header_bytes (0x0), end_byte (0x4),
// gap_limit_ms (0x8), data_limit_ms (0xC); pready is tied high.
// Throughput: one request per cycle while in_ready is high; all decoding is
// combinational between the request and the result register.
// Results reach out_valid from the result register, via skid when stalled.
// Stall: a two-entry output buffer (result register plus skid) keeps
// in_ready high while one result waits; in_ready drops only when both hold.
// Reset (rst_n, synchronous): frame position, timers and flags clear,
// limits return to 100 and 10000 ticks, header and end byte to zero.
module bcd_telemetry_frame_parser #(
  parameter int HEADER_LEN   = bcdtfp_pkg::HEADER_LEN_DEF,
  parameter int FRAME_LENGTH = bcdtfp_pkg::FRAME_LENGTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bcdtfp_pkg::PADDR_W-1:0]      paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_opcode,
  input  logic [7:0]                          in_rx_byte,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_event_res,
  output logic [bcdtfp_pkg::VAL_W-1:0]        out_ac_voltage,
  output logic [bcdtfp_pkg::VAL_W-1:0]        out_power_value,
  output logic [bcdtfp_pkg::VAL_W-1:0]        out_battery_tenths,
  output logic [bcdtfp_pkg::VAL_W-1:0]        out_temperature_value
);
  import bcdtfp_pkg::*;

  cfg_t    cfg;
  result_t res;
  result_t out_data;
  logic    res_valid;
  logic    in_fire;

  // a request is taken whenever the output buffer has a free slot
  assign in_fire = in_valid && in_ready;

  bcdtfp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // frame matching, payload capture, BCD decode and silence timers
  bcdtfp_core #(
    .HEADER_LEN   (HEADER_LEN),
    .FRAME_LENGTH (FRAME_LENGTH)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_fire    (in_fire),
    .in_opcode  (in_opcode),
    .in_rx_byte (in_rx_byte),
    .res_valid  (res_valid),
    .res        (res)
  );

  // result register with skid stage
  bcdtfp_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .up_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_event_res         = out_data.event_res;
  assign out_ac_voltage        = out_data.ac_voltage;
  assign out_power_value       = out_data.power_value;
  assign out_battery_tenths    = out_data.battery_tenths;
  assign out_temperature_value = out_data.temperature_value;

endmodule
